[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Plain property, disabled while in reset
`define QN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication ante |-> cons, disabled while in reset
`define QN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define QN_ASSERT(lbl, clk, rst_n, prop, msg)
`define QN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[hw/rtl/qn_pkg.sv]
package qn_pkg;

    localparam int COMP_W  = 24;
    localparam int MAG_W   = 24;
    localparam int SQ_W    = 47;
    localparam int PAIR_W  = 48;
    localparam int SUMSQ_W = 49;
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int SREM_W  = 34;
    localparam int DEN_W   = 33;
    localparam int DREM_W  = 34;
    localparam int QUOT_W  = 32;
    localparam int UNIT_W  = 32;
    localparam int CFG_W   = 32;
    localparam int LANES   = 4;

    localparam int SUMSQ_STAGES = 3;
    localparam int SQRT_STAGES  = ROOT_W;
    localparam int DIV_STAGES   = QUOT_W;

    localparam logic [CFG_W-1:0]  MIN_SOS_RESET = 32'd1;
    localparam logic [UNIT_W-1:0] ONE_Q30       = 32'h4000_0000;
    localparam logic signed [UNIT_W-1:0] POS_ONE_Q30 = 32'sh4000_0000;
    localparam logic signed [UNIT_W-1:0] NEG_ONE_Q30 = -32'sh4000_0000;

    typedef struct packed {
        logic signed [COMP_W-1:0] comp_w;
        logic signed [COMP_W-1:0] comp_x;
        logic signed [COMP_W-1:0] comp_y;
        logic signed [COMP_W-1:0] comp_z;
    } qn_in_t;

    typedef struct packed {
        logic signed [UNIT_W-1:0] unit_w;
        logic signed [UNIT_W-1:0] unit_x;
        logic signed [UNIT_W-1:0] unit_y;
        logic signed [UNIT_W-1:0] unit_z;
        logic                     degenerate;
    } qn_out_t;

    // Transaction in flight: sign/magnitude form of the components
    typedef struct packed {
        logic                         valid;
        logic                         degen;
        logic [LANES-1:0]             neg;
        logic [LANES-1:0][MAG_W-1:0]  mag;
    } qn_item_t;

    // Transaction leaving the divider lanes
    typedef struct packed {
        logic                         valid;
        logic                         degen;
        logic [LANES-1:0]             neg;
        logic [LANES-1:0][QUOT_W-1:0] quot;
    } qn_quot_t;

endpackage

[hw/rtl/qn_sumsq.sv]
module qn_sumsq
    import qn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  qn_in_t             item,
    input  logic [CFG_W-1:0]   min_sos,
    output qn_item_t           out_item,
    output logic [SUMSQ_W-1:0] sumsq
);

    logic [LANES-1:0][COMP_W-1:0] comp;
    logic [LANES-1:0]             neg_next;
    logic [LANES-1:0][MAG_W-1:0]  mag_next;
    logic [2*MAG_W-1:0]           prod [LANES];

    logic [LANES-1:0]             neg1_reg, neg2_reg, neg3_reg;
    logic [LANES-1:0][MAG_W-1:0]  mag1_reg, mag2_reg, mag3_reg;
    logic [SQ_W-1:0]              sq1_reg [LANES];
    logic [PAIR_W-1:0]            pair2_reg [2];
    logic [SUMSQ_W-1:0]           sum_next, sum3_reg;
    logic                         degen_next, degen3_reg;
    logic [SUMSQ_STAGES-1:0]      valid_reg;

    // Stage 1: sign/magnitude and squares
    always_comb
    begin
        comp[0] = item.comp_w;
        comp[1] = item.comp_x;
        comp[2] = item.comp_y;
        comp[3] = item.comp_z;
        for (int l = 0; l < LANES; l++)
        begin
            neg_next[l] = comp[l][COMP_W-1];
            mag_next[l] = neg_next[l] ? (~comp[l] + 1'b1) : comp[l];
            prod[l]     = mag_next[l] * mag_next[l];
        end
    end

    // Stage 3: final add and threshold test
    always_comb
    begin
        sum_next   = {1'b0, pair2_reg[0]} + {1'b0, pair2_reg[1]};
        degen_next = (sum_next == '0) || (sum_next < {{(SUMSQ_W-CFG_W){1'b0}}, min_sos});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[SUMSQ_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        neg1_reg <= neg_next;
        mag1_reg <= mag_next;
        for (int l = 0; l < LANES; l++)
        begin
            sq1_reg[l] <= prod[l][SQ_W-1:0];
        end
        // Stage 2: pair sums
        neg2_reg     <= neg1_reg;
        mag2_reg     <= mag1_reg;
        pair2_reg[0] <= {1'b0, sq1_reg[0]} + {1'b0, sq1_reg[1]};
        pair2_reg[1] <= {1'b0, sq1_reg[2]} + {1'b0, sq1_reg[3]};
        neg3_reg     <= neg2_reg;
        mag3_reg     <= mag2_reg;
        sum3_reg     <= sum_next;
        degen3_reg   <= degen_next;
    end

    always_comb
    begin
        out_item.valid = valid_reg[SUMSQ_STAGES-1];
        out_item.degen = degen3_reg;
        out_item.neg   = neg3_reg;
        out_item.mag   = mag3_reg;
        sumsq          = sum3_reg;
    end

endmodule

[hw/rtl/qn_sqrt.sv]
module qn_sqrt
    import qn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  qn_item_t           in_item,
    input  logic [SUMSQ_W-1:0] sumsq,
    output qn_item_t           out_item,
    output logic [ROOT_W-1:0]  root
);

    // Index 0 is the stage input, index k>0 the k-th register
    logic [RAD_W-1:0]  rad_s  [SQRT_STAGES+1];
    logic [SREM_W-1:0] rem_s  [SQRT_STAGES+1];
    logic [ROOT_W-1:0] root_s [SQRT_STAGES+1];
    qn_item_t          item_s [SQRT_STAGES+1];

    logic [RAD_W-1:0]  rad_next  [SQRT_STAGES];
    logic [SREM_W-1:0] rem_next  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_next [SQRT_STAGES];

    logic [RAD_W-1:0]  rad_reg  [1:SQRT_STAGES];
    logic [SREM_W-1:0] rem_reg  [1:SQRT_STAGES];
    logic [ROOT_W-1:0] root_reg [1:SQRT_STAGES];
    qn_item_t          item_reg [1:SQRT_STAGES];
    logic [SQRT_STAGES:1] valid_reg;

    logic [SREM_W+1:0] cur  [SQRT_STAGES];
    logic [SREM_W+1:0] trial[SQRT_STAGES];
    logic [SREM_W+1:0] diff [SQRT_STAGES];
    logic              ge   [SQRT_STAGES];

    // Radicand is S * 2^14, one root bit per stage
    always_comb
    begin
        rad_s[0]  = {1'b0, sumsq, 14'b0};
        rem_s[0]  = '0;
        root_s[0] = '0;
        item_s[0] = in_item;
        for (int k = 1; k <= SQRT_STAGES; k++)
        begin
            rad_s[k]        = rad_reg[k];
            rem_s[k]        = rem_reg[k];
            root_s[k]       = root_reg[k];
            item_s[k]       = item_reg[k];
            item_s[k].valid = valid_reg[k];
        end
    end

    // Restoring square root step
    always_comb
    begin
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            cur[k]       = {rem_s[k], rad_s[k][RAD_W-1:RAD_W-2]};
            trial[k]     = {2'b00, root_s[k], 2'b01};
            ge[k]        = cur[k] >= trial[k];
            diff[k]      = cur[k] - trial[k];
            rem_next[k]  = ge[k] ? diff[k][SREM_W-1:0] : cur[k][SREM_W-1:0];
            root_next[k] = {root_s[k][ROOT_W-2:0], ge[k]};
            rad_next[k]  = {rad_s[k][RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= SQRT_STAGES; k++)
            begin
                valid_reg[k] <= item_s[k-1].valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= SQRT_STAGES; k++)
        begin
            rad_reg[k]  <= rad_next[k-1];
            rem_reg[k]  <= rem_next[k-1];
            root_reg[k] <= root_next[k-1];
            item_reg[k] <= item_s[k-1];
        end
    end

    assign out_item = item_s[SQRT_STAGES];
    assign root     = root_s[SQRT_STAGES];

endmodule

[hw/rtl/qn_div.sv]
module qn_div
    import qn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  qn_item_t          in_item,
    input  logic [ROOT_W-1:0] root,
    output qn_quot_t          out_quot
);

    // Four lanes divide (|c| * 2^38 + R) by 2R, one quotient bit per stage
    logic [DEN_W-1:0]                  den_s  [DIV_STAGES+1];
    logic [ROOT_W-1:0]                 low_s  [DIV_STAGES+1];
    logic [LANES-1:0][DREM_W-1:0]      rem_s  [DIV_STAGES+1];
    logic [LANES-1:0][QUOT_W-1:0]      quot_s [DIV_STAGES+1];
    logic                              degen_s[DIV_STAGES+1];
    logic [LANES-1:0]                  neg_s  [DIV_STAGES+1];
    logic                              valid_s[DIV_STAGES+1];

    logic [LANES-1:0][DREM_W-1:0]      rem_next  [DIV_STAGES];
    logic [LANES-1:0][QUOT_W-1:0]      quot_next [DIV_STAGES];
    logic [DREM_W-1:0]                 cur       [DIV_STAGES][LANES];
    logic                              ge        [DIV_STAGES][LANES];

    logic [DEN_W-1:0]                  den_reg  [1:DIV_STAGES];
    logic [ROOT_W-1:0]                 low_reg  [1:DIV_STAGES];
    logic [LANES-1:0][DREM_W-1:0]      rem_reg  [1:DIV_STAGES];
    logic [LANES-1:0][QUOT_W-1:0]      quot_reg [1:DIV_STAGES];
    logic                              degen_reg[1:DIV_STAGES];
    logic [LANES-1:0]                  neg_reg  [1:DIV_STAGES];
    logic [DIV_STAGES:1]               valid_reg;

    // Upper dividend bits are |c| << 6; low bits of the dividend are R
    always_comb
    begin
        den_s[0]   = {root, 1'b0};
        low_s[0]   = root;
        quot_s[0]  = '0;
        degen_s[0] = in_item.degen;
        neg_s[0]   = in_item.neg;
        valid_s[0] = in_item.valid;
        for (int l = 0; l < LANES; l++)
        begin
            rem_s[0][l] = {4'b0000, in_item.mag[l], 6'b000000};
        end
        for (int k = 1; k <= DIV_STAGES; k++)
        begin
            den_s[k]   = den_reg[k];
            low_s[k]   = low_reg[k];
            rem_s[k]   = rem_reg[k];
            quot_s[k]  = quot_reg[k];
            degen_s[k] = degen_reg[k];
            neg_s[k]   = neg_reg[k];
            valid_s[k] = valid_reg[k];
        end
    end

    // Restoring division step per lane
    always_comb
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                cur[k][l]          = {rem_s[k][l][DREM_W-2:0], low_s[k][ROOT_W-1]};
                ge[k][l]           = cur[k][l] >= {1'b0, den_s[k]};
                rem_next[k][l]     = ge[k][l] ? (cur[k][l] - {1'b0, den_s[k]}) : cur[k][l];
                quot_next[k][l]    = {quot_s[k][l][QUOT_W-2:0], ge[k][l]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                valid_reg[k] <= valid_s[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= DIV_STAGES; k++)
        begin
            den_reg[k]   <= den_s[k-1];
            low_reg[k]   <= {low_s[k-1][ROOT_W-2:0], 1'b0};
            rem_reg[k]   <= rem_next[k-1];
            quot_reg[k]  <= quot_next[k-1];
            degen_reg[k] <= degen_s[k-1];
            neg_reg[k]   <= neg_s[k-1];
        end
    end

    always_comb
    begin
        out_quot.valid = valid_s[DIV_STAGES];
        out_quot.degen = degen_s[DIV_STAGES];
        out_quot.neg   = neg_s[DIV_STAGES];
        out_quot.quot  = quot_s[DIV_STAGES];
    end

endmodule

[hw/rtl/quaternion_normalize.sv]
// Channel  | Signals                          | Transaction when
// ---------+----------------------------------+------------------------------
// input    | start, busy, item (qn_in_t)      | start && !busy at clk rise
// result   | done, result (qn_out_t)          | done high, one cycle only
// config   | cfg_valid, cfg_ready, cfg_data   | cfg_valid && cfg_ready
//
// One quaternion accepted per cycle; busy never rises.
// Pipeline: squares and sum, 32 square-root stages (one root bit each),
// 32 divider stages (one quotient bit each, four lanes), then the output register.
// rst_n clears all valid bits and sets min_sum_of_squares to 1.
// The receiver cannot stall; results leave on done with no back-pressure.
`include "assert_macros.svh"

module quaternion_normalize
    import qn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  qn_in_t           item,
    output logic             done,
    output qn_out_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0]    min_sos_reg;
    qn_item_t            sumsq_item;
    logic [SUMSQ_W-1:0]  sumsq;
    qn_item_t            sqrt_item;
    logic [ROOT_W-1:0]   root;
    qn_quot_t            quot;
    logic [QUOT_W-1:0]   mag_sat [LANES];
    logic [UNIT_W-1:0]   unit_next [LANES];
    qn_out_t             result_next, result_reg;
    logic                done_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_sos_reg <= MIN_SOS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            min_sos_reg <= cfg_data;
        end
    end

    qn_sumsq u_sumsq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .item     (item),
        .min_sos  (min_sos_reg),
        .out_item (sumsq_item),
        .sumsq    (sumsq)
    );

    qn_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (sumsq_item),
        .sumsq    (sumsq),
        .out_item (sqrt_item),
        .root     (root)
    );

    qn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (sqrt_item),
        .root     (root),
        .out_quot (quot)
    );

    // Saturate at 1.0, apply sign, identity for small input
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            mag_sat[l]   = (quot.quot[l] > ONE_Q30) ? ONE_Q30 : quot.quot[l];
            unit_next[l] = quot.neg[l] ? (~mag_sat[l] + 1'b1) : mag_sat[l];
        end
        if (quot.degen)
        begin
            result_next.unit_w = POS_ONE_Q30;
            result_next.unit_x = '0;
            result_next.unit_y = '0;
            result_next.unit_z = '0;
        end
        else
        begin
            result_next.unit_w = unit_next[0];
            result_next.unit_x = unit_next[1];
            result_next.unit_y = unit_next[2];
            result_next.unit_z = unit_next[3];
        end
        result_next.degenerate = quot.degen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= quot.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    `QN_ASSERT_IMP(a_degen_identity, clk, rst_n, done && result.degenerate, (result.unit_w == POS_ONE_Q30) && (result.unit_x == '0) && (result.unit_y == '0) && (result.unit_z == '0), "degenerate result is not the identity")
    `QN_ASSERT(a_range, clk, rst_n, !done || ((result.unit_w <= POS_ONE_Q30) && (result.unit_w >= NEG_ONE_Q30) && (result.unit_x <= POS_ONE_Q30) && (result.unit_x >= NEG_ONE_Q30) && (result.unit_y <= POS_ONE_Q30) && (result.unit_y >= NEG_ONE_Q30) && (result.unit_z <= POS_ONE_Q30) && (result.unit_z >= NEG_ONE_Q30)), "output beyond unit range")
    `QN_ASSERT_IMP(a_nonzero, clk, rst_n, done && !result.degenerate, (result.unit_w | result.unit_x | result.unit_y | result.unit_z) != '0, "normalized result is all zero")

endmodule
